/* src/rfb_pkg.sv */
// Shared constants and types for the random blink fader.
`default_nettype none

package rfb_pkg;

    localparam logic [31:0] SEED_RESET      = 32'h7F7F_2C21;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd250;
    localparam logic [7:0]  WAIT_RESET      = 8'd50;
    localparam logic [7:0]  WAIT_START      = 8'd1;
    localparam logic [3:0]  DUTY_FULL       = 4'd10;
    localparam logic [7:0]  PWM_PERIOD      = 8'd10;
    localparam logic [7:0]  PWM_HOLD        = 8'd11;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_ROLL_WAIT = 2'd1,
        REG_SEED      = 2'd2
    } cfg_reg_t;

    typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

/* src/rfb_if.sv */
// Valid/ready channels for tick beats and result beats.
`default_nettype none

interface rfb_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface rfb_result_if;
    logic       valid;
    logic       ready;
    logic       eyes_on;
    logic       rolled;
    logic [7:0] roll_value;
    logic       blinking;

    modport source (output valid, output eyes_on, output rolled, output roll_value,
                    output blinking, input ready);
    modport sink   (input valid, input eyes_on, input rolled, input roll_value,
                    input blinking, output ready);
endinterface

`default_nettype wire

/* src/rfb_lfsr.sv */
// Byte-wise 32-bit LFSR kept as a rotating line of four bytes.
`default_nettype none

module rfb_lfsr
    import rfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [31:0] seed,
    input  wire logic        roll,
    output      byte_t       roll_byte
);

    // Position 0 always holds the current byte, so the index is implicit.
    byte_t gen_reg [4];
    byte_t mix_next;
    byte_t a;
    byte_t b;

    assign a = gen_reg[0];
    assign b = gen_reg[1];
    assign roll_byte = a;

    always_comb
    begin
        mix_next = a ^ {a[5:0], b[7:6]} ^ {a[1:0], b[7:2]} ^ {a[0], b[7:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg[0] <= SEED_RESET[7:0];
            gen_reg[1] <= SEED_RESET[15:8];
            gen_reg[2] <= SEED_RESET[23:16];
            gen_reg[3] <= SEED_RESET[31:24];
        end
        else if (load)
        begin
            gen_reg[0] <= seed[7:0];
            gen_reg[1] <= seed[15:8];
            gen_reg[2] <= seed[23:16];
            gen_reg[3] <= seed[31:24];
        end
        else if (roll)
        begin
            // Replace the current byte and advance to the next one.
            gen_reg[0] <= gen_reg[1];
            gen_reg[1] <= gen_reg[2];
            gen_reg[2] <= gen_reg[3];
            gen_reg[3] <= mix_next;
        end
    end

endmodule

`default_nettype wire

/* src/random_blink_fader_top.sv */
// Random blink fader: one tick beat in, one result beat out, every clock if both sides allow.
// Each accepted tick beat is processed combinationally: the state and result registers load
// at the accepting edge, so the block sustains one beat per cycle while result_out is ready,
// and the result appears in the cycle after acceptance. A tick either counts down the wait,
// rolls the byte-wise LFSR (a byte above threshold starts a blink), or advances the 10-step
// PWM fade. Writing the seed register reloads the generator. No clearing pass follows reset.
`default_nettype none

module random_blink_fader_top
    import rfb_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    rfb_tick_if.sink                    tick_in,
    rfb_result_if.source                result_out,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    byte_t      threshold_reg;
    byte_t      roll_wait_reg;
    logic       blink_reg,  blink_next;
    byte_t      wait_reg,   wait_next;
    byte_t      pwm_reg,    pwm_next;
    logic [3:0] duty_reg,   duty_next;
    logic       rising_reg, rising_next;
    logic       lit_reg,    lit_next;
    byte_t      last_roll_reg, last_roll_next;
    logic       rolled_next;

    logic       out_valid_reg;
    logic       out_eyes_reg;
    logic       out_rolled_reg;
    byte_t      out_value_reg;
    logic       out_blink_reg;

    logic       accept;
    logic       roll;
    logic       seed_load;
    byte_t      roll_byte;
    byte_t      pwm_inc;
    cfg_reg_t   cfg_sel;

    assign cfg_sel   = cfg_reg_t'(cfg_index);
    assign seed_load = cfg_we && (cfg_sel == REG_SEED);

    // Take a new beat whenever the result register is free or draining.
    assign tick_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = tick_in.valid && tick_in.ready;
    assign roll          = accept && tick_in.tick && !blink_reg && (wait_reg <= WAIT_START);

    rfb_lfsr u_lfsr (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (seed_load),
        .seed      (cfg_data),
        .roll      (roll),
        .roll_byte (roll_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            roll_wait_reg <= WAIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                REG_THRESHOLD: threshold_reg <= cfg_data[7:0];
                REG_ROLL_WAIT: roll_wait_reg <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    assign pwm_inc = pwm_reg + 8'd1;

    always_comb
    begin
        blink_next     = blink_reg;
        wait_next      = wait_reg;
        pwm_next       = pwm_reg;
        duty_next      = duty_reg;
        rising_next    = rising_reg;
        lit_next       = lit_reg;
        last_roll_next = last_roll_reg;
        rolled_next    = 1'b0;
        if (tick_in.tick)
        begin
            if (blink_reg)
            begin
                if (pwm_reg == {4'd0, duty_reg})
                    lit_next = 1'b0;
                else if (pwm_reg == 8'd0)
                    lit_next = 1'b1;
                pwm_next = pwm_inc;
                if (pwm_inc == PWM_PERIOD)
                begin
                    pwm_next = 8'd0;
                    if (rising_reg)
                        duty_next = duty_reg + 4'd1;
                    else
                    begin
                        duty_next = duty_reg - 4'd1;
                        // Fully dark: hold off for one long counter wrap.
                        if (duty_next == 4'd0)
                        begin
                            pwm_next    = PWM_HOLD;
                            rising_next = 1'b1;
                        end
                    end
                end
                if (rising_next && duty_next == DUTY_FULL)
                begin
                    lit_next   = 1'b1;
                    blink_next = 1'b0;
                    wait_next  = roll_wait_reg;
                end
            end
            else if (wait_reg <= WAIT_START)
            begin
                last_roll_next = roll_byte;
                rolled_next    = 1'b1;
                if (roll_byte > threshold_reg)
                begin
                    blink_next  = 1'b1;
                    pwm_next    = 8'd0;
                    duty_next   = DUTY_FULL;
                    rising_next = 1'b0;
                end
                else
                    wait_next = roll_wait_reg;
            end
            else
                wait_next = wait_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_reg     <= 1'b0;
            wait_reg      <= WAIT_START;
            pwm_reg       <= 8'd0;
            duty_reg      <= DUTY_FULL;
            rising_reg    <= 1'b0;
            lit_reg       <= 1'b1;
            last_roll_reg <= 8'd0;
        end
        else if (accept)
        begin
            blink_reg     <= blink_next;
            wait_reg      <= wait_next;
            pwm_reg       <= pwm_next;
            duty_reg      <= duty_next;
            rising_reg    <= rising_next;
            lit_reg       <= lit_next;
            last_roll_reg <= last_roll_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_eyes_reg   <= lit_next;
            out_rolled_reg <= rolled_next;
            out_value_reg  <= last_roll_next;
            out_blink_reg  <= blink_next;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.eyes_on    = out_eyes_reg;
    assign result_out.rolled     = out_rolled_reg;
    assign result_out.roll_value = out_value_reg;
    assign result_out.blinking   = out_blink_reg;

    // A blink starts only on a roll, and that beat reports the roll.
    a_blink_start_on_roll: assert property (@(posedge clk) disable iff (!rst_n)
        (blink_reg && !$past(blink_reg)) |-> (out_rolled_reg && out_blink_reg))
        else $error("blink started without a roll");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= DUTY_FULL)
        else $error("duty level above full");

    // Hold a stalled result beat unchanged until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_out.ready) |=>
        (out_valid_reg &&
         $stable({out_eyes_reg, out_rolled_reg, out_value_reg, out_blink_reg})))
        else $error("result beat changed while stalled");

    a_lit_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        !blink_reg |-> lit_reg)
        else $error("eyes dark while waiting");

endmodule

`default_nettype wire
